FILE: sv/telemetry_frame_encoder_defines.svh
// Assertion macros used by the telemetry frame encoder checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TELEMETRY_FRAME_ENCODER_DEFINES_SVH
`define TELEMETRY_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TFE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tfe assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tfe assertion failed");

`endif

FILE: sv/tfe_pkg.sv
// Shared types and constants of the telemetry frame encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tfe_pkg;

  localparam int unsigned FrameBytes = 8;   // raw bytes per frame, checksum included
  localparam int unsigned IdxW       = $clog2(FrameBytes);
  localparam int unsigned QDepth     = 2;   // frames buffered between front and back
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  localparam logic [7:0] EscMark   = 8'h7D;
  localparam logic [7:0] FrameMark = 8'h7E;
  localparam logic [7:0] EscFlip   = 8'h20;
  localparam logic [7:0] ChkInit   = 8'hFF;
  localparam logic [7:0] VoidTail  = 8'hFF;

  typedef enum logic {
    ActData = 1'b0,
    ActVoid = 1'b1
  } action_e;

  // One frame in line order before escaping; entry 0 goes out first.
  typedef struct packed {
    logic [FrameBytes-1:0][7:0] bytes;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: sv/tfe_front.sv
// Request front end: builds the raw frame and its checksum combinationally.
// Depends on tfe_pkg.
`timescale 1ns / 1ps

module tfe_front (
  input  logic          push_i,
  input  logic          q_full_i,
  input  logic          action_i,
  input  logic [7:0]    frame_type_i,
  input  logic [15:0]   data_ident_i,
  input  logic [31:0]   payload_i,
  output logic          q_wr_o,
  output tfe_pkg::frame_t q_wdata_o
);
  import tfe_pkg::*;

  logic [6:0][7:0] raw;
  logic [7:0]      sum;
  logic [10:0]     total;
  logic [8:0]      fold;

  assign q_wr_o = push_i & ~q_full_i;

  // End-around-carry sum over the seven header and value bytes: add them
  // all as a tree, then fold the carries back in twice.
  always_comb begin
    raw[0] = frame_type_i;
    raw[1] = data_ident_i[7:0];
    raw[2] = data_ident_i[15:8];
    raw[3] = payload_i[7:0];
    raw[4] = payload_i[15:8];
    raw[5] = payload_i[23:16];
    raw[6] = payload_i[31:24];
    total  = ({3'b000, raw[0]} + {3'b000, raw[1]}) +
             ({3'b000, raw[2]} + {3'b000, raw[3]}) +
             (({3'b000, raw[4]} + {3'b000, raw[5]}) + {3'b000, raw[6]});
    fold   = {1'b0, total[7:0]} + {6'b000000, total[10:8]};
    sum    = fold[7:0] + {7'b0, fold[8]};
  end

  always_comb begin
    if (action_e'(action_i) == ActVoid) begin
      q_wdata_o.bytes    = '0;
      q_wdata_o.bytes[7] = VoidTail;
    end else begin
      q_wdata_o.bytes[6:0] = raw;
      q_wdata_o.bytes[7]   = ChkInit - sum;
    end
  end

endmodule

FILE: sv/tfe_fifo.sv
// Small frame queue between the request front end and the byte sender.
// Depends on tfe_pkg.
`timescale 1ns / 1ps

module tfe_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  tfe_pkg::frame_t    wdata_i,
  input  logic               rd_i,
  output tfe_pkg::frame_t    rdata_o,
  output tfe_pkg::q_status_t status_o
);
  import tfe_pkg::*;

  frame_t           mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_wr   = wr_i & ~status_o.full;
  assign do_rd   = rd_i & ~status_o.empty;
  assign rdata_o = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: sv/tfe_back.sv
// Byte sender: walks the head frame, inserts escape pairs, registers output.
// Depends on tfe_pkg.
`timescale 1ns / 1ps

module tfe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfe_pkg::frame_t    q_data_i,
  input  tfe_pkg::q_status_t q_status_i,
  output logic               q_rd_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [7:0]         out_byte_o,
  output logic               last_o
);
  import tfe_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            esc_q, esc_d;
  logic            valid_q, valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic [7:0]      cur;
  logic            special, at_end, advance, go, step;

  assign cur     = q_data_i.bytes[idx_q];
  assign special = (cur == EscMark) || (cur == FrameMark);
  assign at_end  = (idx_q == IdxW'(FrameBytes - 1));
  assign advance = ~valid_q | pop_i;
  assign go      = advance & ~q_status_i.empty;

  always_comb begin
    idx_d   = idx_q;
    esc_d   = esc_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    step    = 1'b0;
    q_rd_o  = 1'b0;
    if (go) begin
      valid_d = 1'b1;
      if (esc_q) begin
        // second half of an escape pair
        byte_d = cur ^ EscFlip;
        last_d = at_end;
        esc_d  = 1'b0;
        step   = 1'b1;
      end else if (special) begin
        byte_d = EscMark;
        last_d = 1'b0;
        esc_d  = 1'b1;
      end else begin
        byte_d = cur;
        last_d = at_end;
        step   = 1'b1;
      end
      if (step) begin
        if (at_end) begin
          idx_d  = '0;
          q_rd_o = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end else if (advance) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      esc_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      esc_q   <= esc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign empty_o    = ~valid_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;

endmodule

FILE: sv/telemetry_frame_encoder.sv
// Telemetry frame encoder top level: front end, frame queue, byte sender.
// Depends on tfe_pkg, tfe_front, tfe_fifo and tfe_back.
//
// Usage:
//   Request side is a queue write port: drive action_i and the frame fields,
//   raise push; the transfer happens on a rising edge with full low.
//   Result side is a queue read port: while empty is low, out_byte_o and
//   last_o show the oldest line byte; pulling pop takes it on that edge.
//   A data frame yields 8 to 16 bytes (escape pairs for 0x7D / 0x7E),
//   a void frame exactly 8; last_o marks the final byte of each frame.
// Timing:
//   A request is written into the queue first; its first byte then passes
//   through the sender's output register before it shows. The sender
//   puts out one byte per cycle while pop is high; the line byte count
//   of a frame sets how long it is sent. Two frames wait in the queue,
//   so requests keep flowing while the receiver reads.
// Reset and stall:
//   Reset empties the queue and the output register; nothing is sent.
//   If pop stays low, the output byte holds, the sender stops, the queue
//   fills and then full rises; no byte is dropped or repeated.
`timescale 1ns / 1ps

module telemetry_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [7:0]  frame_type_i,
  input  logic [15:0] data_ident_i,
  input  logic [31:0] payload_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);
  import tfe_pkg::*;

  q_status_t q_status;
  frame_t    q_wdata;
  frame_t    q_rdata;
  logic      q_wr;
  logic      q_rd;

  assign full = q_status.full;

  // Front: checksum and frame layout, written straight into the queue.
  tfe_front u_front (
    .push_i       (push),
    .q_full_i     (q_status.full),
    .action_i     (action_i),
    .frame_type_i (frame_type_i),
    .data_ident_i (data_ident_i),
    .payload_i    (payload_i),
    .q_wr_o       (q_wr),
    .q_wdata_o    (q_wdata)
  );

  tfe_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wdata_i  (q_wdata),
    .rd_i     (q_rd),
    .rdata_o  (q_rdata),
    .status_o (q_status)
  );

  // Back: one line byte per cycle while pop is high; the head frame leaves
  // the queue when its final byte is registered.
  tfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_data_i   (q_rdata),
    .q_status_i (q_status),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule

FILE: sv/tfe_checker.sv
// Port-level checker for the telemetry frame encoder, bound to the top.
// Depends on tfe_pkg and telemetry_frame_encoder_defines.svh.
`timescale 1ns / 1ps
`include "telemetry_frame_encoder_defines.svh"

module tfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       last_o
);
  import tfe_pkg::*;

  logic [2:0] open_q, open_d;
  logic       esc_seen_q, esc_seen_d;
  logic       in_xfer, out_xfer;

  assign in_xfer  = push & ~full;
  assign out_xfer = pop & ~empty;

  always_comb begin
    open_d     = open_q;
    esc_seen_d = esc_seen_q;
    if (in_xfer && !(out_xfer && last_o)) begin
      open_d = open_q + 1'b1;
    end else if (!in_xfer && out_xfer && last_o) begin
      open_d = open_q - 1'b1;
    end
    if (out_xfer) begin
      esc_seen_d = (out_byte_o == EscMark);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= '0;
      esc_seen_q <= 1'b0;
    end else begin
      open_q     <= open_d;
      esc_seen_q <= esc_seen_d;
    end
  end

  `TFE_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_byte_o) && $stable(last_o))
  `TFE_ASSERT_NOW(a_no_frame_mark, clk_i, rst_ni, !empty, out_byte_o != FrameMark)
  `TFE_ASSERT_NOW(a_escape_not_last, clk_i, rst_ni, !empty && last_o, out_byte_o != EscMark)
  `TFE_ASSERT_NOW(a_escape_pair, clk_i, rst_ni, esc_seen_q && !empty, (out_byte_o == (EscMark ^ EscFlip)) || (out_byte_o == (FrameMark ^ EscFlip)))
  `TFE_ASSERT_NOW(a_no_orphan_byte, clk_i, rst_ni, open_q == 3'd0, empty)

endmodule

bind telemetry_frame_encoder tfe_checker u_tfe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_byte_o (out_byte_o),
  .last_o     (last_o)
);
